[hw/rtl/gsbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbb_pkg
// Shared widths and pipeline payload types for the splat bounding box block.
// ----------------------------------------------------------------------------
package gsbb_pkg;

  localparam int IDX_W  = 32;
  localparam int POS_W  = 32;
  localparam int SCL_W  = 31;
  localparam int QUAT_W = 8;
  localparam int VEC_W  = SCL_W + 2;
  localparam int MAG_W  = 17;
  localparam int PROD_W = VEC_W + MAG_W;
  localparam int RND_SH = 14;
  localparam int EXT_W  = PROD_W - RND_SH;
  localparam int DIFF_W = EXT_W + 2;

  localparam int IN_DATA_W  = 256;
  localparam int OUT_DATA_W = 224;

  typedef struct packed {
    logic [IDX_W-1:0]            index;
    logic [2:0][POS_W-1:0]       pos;
    logic [2:0][SCL_W-1:0]       scale;
    logic [QUAT_W-1:0]           qw;
    logic [QUAT_W-1:0]           qx;
    logic [QUAT_W-1:0]           qy;
    logic [QUAT_W-1:0]           qz;
  } splat_t;

  typedef struct packed {
    logic [IDX_W-1:0]            index;
    logic [2:0][POS_W-1:0]       pos;
    logic [2:0][VEC_W-1:0]       vec;
  } side_t;

  // mag[j][k] is the magnitude of world component j of rotated axis k, times 16384.
  typedef struct packed {
    side_t                       side;
    logic [2:0][2:0][MAG_W-1:0]  mag;
  } coef_t;

  typedef struct packed {
    logic [IDX_W-1:0]            index;
    logic [2:0][POS_W-1:0]       pos;
    logic [2:0][EXT_W-1:0]       ext;
  } ext_t;

  typedef struct packed {
    logic [IDX_W-1:0]            index;
    logic [2:0][POS_W-1:0]       lo;
    logic [2:0][POS_W-1:0]       hi;
  } box_t;

endpackage

[hw/rtl/gsbb_coef.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbb_coef
// Two stages: quaternion part products and tripled scales, then the rotation
// coefficient magnitudes.
// ----------------------------------------------------------------------------
module gsbb_coef (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gsbb_pkg::splat_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gsbb_pkg::coef_t out_data
);
  import gsbb_pkg::*;

  logic               s1_vld_r, s1_vld_nxt;
  logic               s2_vld_r, s2_vld_nxt;
  logic               s1_adv, s2_adv;
  side_t              s1_side_r;
  logic signed [15:0] sq_r [3];
  logic signed [15:0] aq_r [3];
  logic signed [15:0] qxy_r, qxz_r, qyz_r;
  coef_t              s2_r;
  logic signed [18:0] m [3][3];
  logic [2:0][2:0][MAG_W-1:0] mag;
  side_t              side_nxt;

  assign s2_adv   = !s2_vld_r || out_ready;
  assign s1_adv   = !s1_vld_r || s2_adv;
  assign in_ready = s1_adv;

  always_comb begin
    s1_vld_nxt = s1_adv ? in_valid : s1_vld_r;
    s2_vld_nxt = s2_adv ? s1_vld_r : s2_vld_r;
  end

  always_comb begin
    side_nxt.index = in_data.index;
    side_nxt.pos   = in_data.pos;
    for (int k = 0; k < 3; k++) begin
      side_nxt.vec[k] = {2'b00, in_data.scale[k]} + {1'b0, in_data.scale[k], 1'b0};
    end
  end

  always_comb begin
    m[0][0] = 19'sd16384 - 19'sd2 * (sq_r[1] + sq_r[2]);
    m[1][1] = 19'sd16384 - 19'sd2 * (sq_r[0] + sq_r[2]);
    m[2][2] = 19'sd16384 - 19'sd2 * (sq_r[0] + sq_r[1]);
    m[0][1] = 19'sd2 * (qxy_r - aq_r[2]);
    m[1][0] = 19'sd2 * (qxy_r + aq_r[2]);
    m[0][2] = 19'sd2 * (qxz_r + aq_r[1]);
    m[2][0] = 19'sd2 * (qxz_r - aq_r[1]);
    m[1][2] = 19'sd2 * (qyz_r - aq_r[0]);
    m[2][1] = 19'sd2 * (qyz_r + aq_r[0]);
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        mag[j][k] = m[j][k][18] ? MAG_W'(-m[j][k]) : MAG_W'(m[j][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_side_r <= side_nxt;
      sq_r[0]   <= $signed(in_data.qx) * $signed(in_data.qx);
      sq_r[1]   <= $signed(in_data.qy) * $signed(in_data.qy);
      sq_r[2]   <= $signed(in_data.qz) * $signed(in_data.qz);
      aq_r[0]   <= $signed(in_data.qw) * $signed(in_data.qx);
      aq_r[1]   <= $signed(in_data.qw) * $signed(in_data.qy);
      aq_r[2]   <= $signed(in_data.qw) * $signed(in_data.qz);
      qxy_r     <= $signed(in_data.qx) * $signed(in_data.qy);
      qxz_r     <= $signed(in_data.qx) * $signed(in_data.qz);
      qyz_r     <= $signed(in_data.qy) * $signed(in_data.qz);
    end
    if (s2_adv) begin
      s2_r.side <= s1_side_r;
      s2_r.mag  <= mag;
    end
  end

  assign out_valid = s2_vld_r;
  assign out_data  = s2_r;

endmodule

[hw/rtl/gsbb_extent.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbb_extent
// Two stages: nine scale-by-coefficient products, then rounding to Q16.16 and
// the largest extent per world axis.
// ----------------------------------------------------------------------------
module gsbb_extent (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gsbb_pkg::coef_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gsbb_pkg::ext_t  out_data
);
  import gsbb_pkg::*;

  logic               s3_vld_r, s3_vld_nxt;
  logic               s4_vld_r, s4_vld_nxt;
  logic               s3_adv, s4_adv;
  logic [IDX_W-1:0]   s3_index_r;
  logic [2:0][POS_W-1:0] s3_pos_r;
  logic [PROD_W-1:0]  prod_r [3][3];
  logic [PROD_W-1:0]  prod_nxt [3][3];
  logic [PROD_W-1:0]  rsum [3][3];
  logic [EXT_W-1:0]   e [3][3];
  logic [2:0][EXT_W-1:0] ext_nxt;
  logic [EXT_W-1:0]   m01;
  ext_t               s4_r;

  assign s4_adv   = !s4_vld_r || out_ready;
  assign s3_adv   = !s3_vld_r || s4_adv;
  assign in_ready = s3_adv;

  always_comb begin
    s3_vld_nxt = s3_adv ? in_valid : s3_vld_r;
    s4_vld_nxt = s4_adv ? s3_vld_r : s4_vld_r;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[j][k] = in_data.side.vec[k] * in_data.mag[j][k];
      end
    end
  end

  always_comb begin
    m01 = '0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        rsum[j][k] = prod_r[j][k] + PROD_W'(8192);
        e[j][k]    = rsum[j][k][PROD_W-1:RND_SH];
      end
      m01        = (e[j][0] > e[j][1]) ? e[j][0] : e[j][1];
      ext_nxt[j] = (m01 > e[j][2]) ? m01 : e[j][2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s3_vld_nxt;
      s4_vld_r <= s4_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_index_r <= in_data.side.index;
      s3_pos_r   <= in_data.side.pos;
      prod_r     <= prod_nxt;
    end
    if (s4_adv) begin
      s4_r.index <= s3_index_r;
      s4_r.pos   <= s3_pos_r;
      s4_r.ext   <= ext_nxt;
    end
  end

  assign out_valid = s4_vld_r;
  assign out_data  = s4_r;

endmodule

[hw/rtl/gsbb_bound.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbb_bound
// Output stage: centre minus and plus the half extent, saturated to 32 bits.
// ----------------------------------------------------------------------------
module gsbb_bound (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gsbb_pkg::ext_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gsbb_pkg::box_t  out_data
);
  import gsbb_pkg::*;

  logic                     s5_vld_r, s5_vld_nxt;
  logic                     s5_adv;
  logic signed [DIFF_W-1:0] p_ext, e_ext, lo_w, hi_w;
  box_t                     box_nxt;
  box_t                     s5_r;

  function automatic logic [POS_W-1:0] sat32(input logic signed [DIFF_W-1:0] v);
    logic [POS_W-1:0] r;
    if ((v[DIFF_W-1:POS_W-1] == '0) || (v[DIFF_W-1:POS_W-1] == '1)) begin
      r = v[POS_W-1:0];
    end else if (v[DIFF_W-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  assign s5_adv   = !s5_vld_r || out_ready;
  assign in_ready = s5_adv;

  always_comb begin
    s5_vld_nxt    = s5_adv ? in_valid : s5_vld_r;
    box_nxt.index = in_data.index;
    p_ext = '0;
    e_ext = '0;
    lo_w  = '0;
    hi_w  = '0;
    for (int j = 0; j < 3; j++) begin
      p_ext = {{(DIFF_W-POS_W){in_data.pos[j][POS_W-1]}}, in_data.pos[j]};
      e_ext = {2'b00, in_data.ext[j]};
      lo_w  = p_ext - e_ext;
      hi_w  = p_ext + e_ext;
      box_nxt.lo[j] = sat32(lo_w);
      box_nxt.hi[j] = sat32(hi_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s5_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_adv) begin
      s5_r <= box_nxt;
    end
  end

  assign out_valid = s5_vld_r;
  assign out_data  = s5_r;

endmodule

[hw/rtl/gaussian_splat_bounding_box_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_splat_bounding_box_top
// Axis-aligned box of a quaternion-rotated, scaled Gaussian splat.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  in_*     slave      splat index, centre, scales, quaternion
//  out_*    master     splat index, box min and max per axis
//
// One beat is taken per cycle unless an output stall has filled every stage.
// Five register stages lie from input to output: coefficient products,
// coefficients, scale products, rounding and maximum, and saturated bounds.
// Reset clears only the stage valid bits. A stall on the output holds the
// last stage, and empty stages upstream still fill, so nothing is lost.
// ----------------------------------------------------------------------------
module gaussian_splat_bounding_box_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // splat_index, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
  // quat_w, quat_x, quat_y, quat_z, zero pad
  input  logic [gsbb_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // result_index, box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z
  output logic [gsbb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import gsbb_pkg::*;

  splat_t splat;
  coef_t  coef;
  ext_t   ext;
  box_t   box;
  logic   c_vld, c_rdy, e_vld, e_rdy;

  always_comb begin
    splat.index    = in_tdata[31:0];
    splat.pos[0]   = in_tdata[63:32];
    splat.pos[1]   = in_tdata[95:64];
    splat.pos[2]   = in_tdata[127:96];
    splat.scale[0] = in_tdata[158:128];
    splat.scale[1] = in_tdata[189:159];
    splat.scale[2] = in_tdata[220:190];
    splat.qw       = in_tdata[228:221];
    splat.qx       = in_tdata[236:229];
    splat.qy       = in_tdata[244:237];
    splat.qz       = in_tdata[252:245];
  end

  gsbb_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (splat),
    .out_valid (c_vld),
    .out_ready (c_rdy),
    .out_data  (coef)
  );

  gsbb_extent u_extent (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_vld),
    .in_ready  (c_rdy),
    .in_data   (coef),
    .out_valid (e_vld),
    .out_ready (e_rdy),
    .out_data  (ext)
  );

  gsbb_bound u_bound (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_vld),
    .in_ready  (e_rdy),
    .in_data   (ext),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (box)
  );

  assign out_tdata = {box.hi[2], box.lo[2], box.hi[1], box.lo[1],
                      box.hi[0], box.lo[0], box.index};

endmodule

[hw/rtl/gsbb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbb_checker
// Port-level checks on the splat bounding box block, bound to the top level.
// ----------------------------------------------------------------------------
module gsbb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gsbb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import gsbb_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[63:32]) <= $signed(out_tdata[95:64])) &&
                   ($signed(out_tdata[127:96]) <= $signed(out_tdata[159:128])) &&
                   ($signed(out_tdata[191:160]) <= $signed(out_tdata[223:192])))
    else $error("box minimum above maximum");

endmodule

bind gaussian_splat_bounding_box_top gsbb_checker u_gsbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
